// File: rtl/keyboard_report_slot_composer_macros.svh
// Assertion macros for the keyboard report slot composer.
`ifndef KEYBOARD_REPORT_SLOT_COMPOSER_MACROS_SVH
`define KEYBOARD_REPORT_SLOT_COMPOSER_MACROS_SVH

`ifndef NO_ASSERTIONS
`define KRSC_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("krsc check failed");
`define KRSC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("krsc check failed");
`else
`define KRSC_ASSERT_NOW(lbl, ante, cons)
`define KRSC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: rtl/krsc_pkg.sv
`default_nettype none
package krsc_pkg;

	localparam int NUM_SLOTS = 6;
	localparam int IDX_W = 3;
	localparam int CODE_W = 8;

	localparam logic KIND_EVENT = 1'b0;
	localparam logic KIND_TICK = 1'b1;
	localparam logic [4:0] MOD_PREFIX = 5'b11100;

	typedef logic [CODE_W-1:0] code_t;
	typedef logic [NUM_SLOTS-1:0][CODE_W-1:0] slot_vec_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_APPLY,
		ST_PACK,
		ST_FILL,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic is_zero;
		logic is_hit;
	} cmp_t;

	typedef struct packed {
		logic en;
		logic [IDX_W-1:0] idx;
		code_t data;
	} slot_wr_t;

	function automatic logic is_modifier(code_t code);
		return code[CODE_W-1:3] == MOD_PREFIX;
	endfunction

	function automatic code_t modifier_mask(code_t code);
		return code_t'(1) << code[2:0];
	endfunction

endpackage
`default_nettype wire

// File: rtl/keyboard_report_slot_composer.sv
// Channel | Handshake            | Word
// input   | in_valid, in_ready   | kind, key_code, pressed
// output  | out_valid, out_ready | modifier_bits, slot0 .. slot5
//
// A modifier event goes straight to the update step; any other key event first
// makes one pass over the six slots through a single comparator, then the update.
// A tick with a pending change runs a pack pass over the slots, then the
// zero fill of the freed tail, then the load of the output register.
// A tick without a pending change is absorbed in its accept cycle.
// Reset clears all slots, the modifier byte and the change mark; a stalled
// output word holds the report until it is taken, and a further report waits
// in its last step with input held off until the output register is free.
`default_nettype none
`include "keyboard_report_slot_composer_macros.svh"
module keyboard_report_slot_composer (
	input wire clk,
	input wire arst_n,
	input wire in_valid,
	output logic in_ready,
	input wire kind,
	input wire [7:0] key_code,
	input wire pressed,
	output logic out_valid,
	input wire out_ready,
	output logic [7:0] modifier_bits,
	output logic [7:0] slot0,
	output logic [7:0] slot1,
	output logic [7:0] slot2,
	output logic [7:0] slot3,
	output logic [7:0] slot4,
	output logic [7:0] slot5
);

	localparam logic [krsc_pkg::IDX_W-1:0] LAST_IDX = krsc_pkg::IDX_W'(krsc_pkg::NUM_SLOTS - 1);
	localparam logic [krsc_pkg::IDX_W-1:0] END_IDX = krsc_pkg::IDX_W'(krsc_pkg::NUM_SLOTS);

	krsc_pkg::state_t state_q, state_d;
	logic [krsc_pkg::IDX_W-1:0] idx_q;
	logic [krsc_pkg::IDX_W-1:0] wr_idx_q;
	krsc_pkg::code_t code_q;
	logic pressed_q;
	logic is_mod_q;
	logic hit_found_q;
	logic [krsc_pkg::IDX_W-1:0] hit_idx_q;
	logic free_found_q;
	logic [krsc_pkg::IDX_W-1:0] free_idx_q;
	krsc_pkg::code_t mod_q;
	logic dirty_q;
	logic out_valid_q;
	krsc_pkg::code_t out_mod_q;
	krsc_pkg::slot_vec_t out_slots_q;

	logic in_fire;
	logic emit_go;
	krsc_pkg::slot_wr_t slot_wr;
	krsc_pkg::code_t rd_data;
	krsc_pkg::slot_vec_t slots;
	krsc_pkg::cmp_t cmp;

	krsc_slot_file u_slot_file (
		.clk(clk),
		.arst_n(arst_n),
		.wr(slot_wr),
		.rd_idx(idx_q),
		.rd_data(rd_data),
		.slots(slots)
	);

	krsc_cmp_unit u_cmp_unit (
		.slot_value(rd_data),
		.key_code(code_q),
		.result(cmp)
	);

	assign in_fire = in_valid && in_ready;
	assign emit_go = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			krsc_pkg::ST_IDLE: begin
				if (in_fire) begin
					if (kind == krsc_pkg::KIND_TICK) begin
						state_d = dirty_q ? krsc_pkg::ST_PACK : krsc_pkg::ST_IDLE;
					end else if (krsc_pkg::is_modifier(key_code)) begin
						state_d = krsc_pkg::ST_APPLY;
					end else begin
						state_d = krsc_pkg::ST_SCAN;
					end
				end
			end
			krsc_pkg::ST_SCAN: begin
				if (idx_q == LAST_IDX) begin
					state_d = krsc_pkg::ST_APPLY;
				end
			end
			krsc_pkg::ST_APPLY: state_d = krsc_pkg::ST_IDLE;
			krsc_pkg::ST_PACK: begin
				if (idx_q == LAST_IDX) begin
					state_d = krsc_pkg::ST_FILL;
				end
			end
			krsc_pkg::ST_FILL: begin
				if (wr_idx_q == END_IDX) begin
					state_d = krsc_pkg::ST_EMIT;
				end
			end
			krsc_pkg::ST_EMIT: begin
				if (emit_go) begin
					state_d = krsc_pkg::ST_IDLE;
				end
			end
			default: state_d = krsc_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		slot_wr = '0;
		case (state_q)
			krsc_pkg::ST_IDLE: in_ready = 1'b1;
			krsc_pkg::ST_APPLY: begin
				if (!is_mod_q) begin
					if (!pressed_q && hit_found_q) begin
						slot_wr.en = 1'b1;
						slot_wr.idx = hit_idx_q;
						slot_wr.data = '0;
					end else if (pressed_q && !hit_found_q && free_found_q) begin
						slot_wr.en = 1'b1;
						slot_wr.idx = free_idx_q;
						slot_wr.data = code_q;
					end
				end
			end
			krsc_pkg::ST_PACK: begin
				if (!cmp.is_zero) begin
					slot_wr.en = 1'b1;
					slot_wr.idx = wr_idx_q;
					slot_wr.data = rd_data;
				end
			end
			krsc_pkg::ST_FILL: begin
				if (wr_idx_q != END_IDX) begin
					slot_wr.en = 1'b1;
					slot_wr.idx = wr_idx_q;
					slot_wr.data = '0;
				end
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= krsc_pkg::ST_IDLE;
			idx_q <= '0;
			wr_idx_q <= '0;
			hit_found_q <= 1'b0;
			free_found_q <= 1'b0;
			mod_q <= '0;
			dirty_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == krsc_pkg::ST_EMIT && emit_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				krsc_pkg::ST_IDLE: begin
					idx_q <= '0;
					wr_idx_q <= '0;
					hit_found_q <= 1'b0;
					free_found_q <= 1'b0;
				end
				krsc_pkg::ST_SCAN: begin
					if (!free_found_q && cmp.is_zero) begin
						free_found_q <= 1'b1;
					end
					if (!hit_found_q && cmp.is_hit) begin
						hit_found_q <= 1'b1;
					end
					idx_q <= idx_q + krsc_pkg::IDX_W'(1);
				end
				krsc_pkg::ST_APPLY: begin
					if (is_mod_q) begin
						mod_q <= pressed_q ? (mod_q | krsc_pkg::modifier_mask(code_q))
							: (mod_q & ~krsc_pkg::modifier_mask(code_q));
						dirty_q <= 1'b1;
					end else if (slot_wr.en) begin
						dirty_q <= 1'b1;
					end
				end
				krsc_pkg::ST_PACK: begin
					if (!cmp.is_zero) begin
						wr_idx_q <= wr_idx_q + krsc_pkg::IDX_W'(1);
					end
					idx_q <= idx_q + krsc_pkg::IDX_W'(1);
				end
				krsc_pkg::ST_FILL: begin
					if (wr_idx_q != END_IDX) begin
						wr_idx_q <= wr_idx_q + krsc_pkg::IDX_W'(1);
					end
				end
				krsc_pkg::ST_EMIT: begin
					if (emit_go) begin
						dirty_q <= 1'b0;
					end
				end
				default: begin
					idx_q <= '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			code_q <= key_code;
			pressed_q <= pressed;
			is_mod_q <= krsc_pkg::is_modifier(key_code);
		end
		if (state_q == krsc_pkg::ST_SCAN) begin
			if (!free_found_q && cmp.is_zero) begin
				free_idx_q <= idx_q;
			end
			if (!hit_found_q && cmp.is_hit) begin
				hit_idx_q <= idx_q;
			end
		end
		if (state_q == krsc_pkg::ST_EMIT && emit_go) begin
			out_mod_q <= mod_q;
			out_slots_q <= slots;
		end
	end

	assign out_valid = out_valid_q;
	assign modifier_bits = out_mod_q;
	assign slot0 = out_slots_q[0];
	assign slot1 = out_slots_q[1];
	assign slot2 = out_slots_q[2];
	assign slot3 = out_slots_q[3];
	assign slot4 = out_slots_q[4];
	assign slot5 = out_slots_q[5];

	`KRSC_ASSERT_NEXT(a_mod_goes_apply,
		in_fire && kind == krsc_pkg::KIND_EVENT && krsc_pkg::is_modifier(key_code),
		state_q == krsc_pkg::ST_APPLY)
	`KRSC_ASSERT_NEXT(a_dirty_tick_packs,
		in_fire && kind == krsc_pkg::KIND_TICK && dirty_q,
		state_q == krsc_pkg::ST_PACK)
	`KRSC_ASSERT_NEXT(a_emit_loads,
		state_q == krsc_pkg::ST_EMIT && emit_go,
		out_valid_q && !dirty_q)
	`KRSC_ASSERT_NOW(a_scan_index_range,
		state_q == krsc_pkg::ST_SCAN || state_q == krsc_pkg::ST_PACK,
		idx_q <= LAST_IDX && wr_idx_q <= idx_q)

endmodule
`default_nettype wire

// File: rtl/krsc_cmp_unit.sv
`default_nettype none
module krsc_cmp_unit (
	input wire krsc_pkg::code_t slot_value,
	input wire krsc_pkg::code_t key_code,
	output krsc_pkg::cmp_t result
);

	assign result.is_zero = (slot_value == '0);
	assign result.is_hit = (slot_value == key_code);

endmodule
`default_nettype wire

// File: rtl/krsc_slot_file.sv
`default_nettype none
module krsc_slot_file (
	input wire clk,
	input wire arst_n,
	input wire krsc_pkg::slot_wr_t wr,
	input wire [krsc_pkg::IDX_W-1:0] rd_idx,
	output krsc_pkg::code_t rd_data,
	output krsc_pkg::slot_vec_t slots
);

	krsc_pkg::slot_vec_t slots_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_q <= '0;
		end else if (wr.en) begin
			for (int i = 0; i < krsc_pkg::NUM_SLOTS; i++) begin
				if (wr.idx == krsc_pkg::IDX_W'(i)) begin
					slots_q[i] <= wr.data;
				end
			end
		end
	end

	always_comb begin
		rd_data = '0;
		for (int i = 0; i < krsc_pkg::NUM_SLOTS; i++) begin
			if (rd_idx == krsc_pkg::IDX_W'(i)) begin
				rd_data = slots_q[i];
			end
		end
	end

	assign slots = slots_q;

endmodule
`default_nettype wire
